### src/nbga_pkg.sv
// ----------------------------------------------------------------------------
// nbga_pkg
// Shared constants and types for the softened gravity accelerator.
// ----------------------------------------------------------------------------
`default_nettype none

package nbga_pkg;

	localparam int MAX_PARTICLES_DEF = 1024;

	// Reciprocal square root: linear first guess plus Newton steps in Q2.30
	localparam int NEWTON_STEPS = 6;
	localparam int RSQ_LAT      = 2 + 4 * NEWTON_STEPS;
	localparam logic [31:0] Q30_THREE = 32'd3221225472;
	localparam logic [31:0] Y_CAP     = 32'd2147483648;
	localparam logic [31:0] GUESS_C0  = 32'd2505397589;
	localparam logic [31:0] GUESS_C1  = 32'd1431655765;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [1:0] REG_COUNT = 2'd0;
	localparam logic [1:0] REG_GRAV  = 2'd1;
	localparam logic [1:0] REG_SOFT  = 2'd2;

	localparam logic [10:0] COUNT_RST = 11'd1;
	localparam logic [31:0] GRAV_RST  = 32'h0001_0000;
	localparam logic [63:0] SOFT_RST  = 64'h0000_0001_0000_0000;

	// in-flight counter width, covers the pair pipeline depth
	localparam int INFL_W = 8;

	typedef struct packed {
		logic [31:0] m;
		logic [31:0] z;
		logic [31:0] y;
		logic [31:0] x;
	} particle_t;

	typedef struct packed {
		logic             valid;
		logic             zero;
		logic [2:0]       neg;
		logic [2:0]       tovf;
		logic [2:0][62:0] mag;
	} term_t;

endpackage

`default_nettype wire

### src/nbga_ram.sv
// ----------------------------------------------------------------------------
// nbga_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module nbga_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### src/nbga_rsqrt.sv
// ----------------------------------------------------------------------------
// nbga_rsqrt
// Pipelined reciprocal square root: linear guess, then fixed Newton steps,
// four register stages per step, one input per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module nbga_rsqrt (
	input  logic        clk,
	input  logic [31:0] xq,
	output logic [31:0] y
);
	import nbga_pkg::*;

	logic [63:0] c1x_q;
	logic [31:0] xg_q;
	logic [31:0] y_q  [NEWTON_STEPS+1];
	logic [31:0] x_q  [NEWTON_STEPS];
	logic [31:0] ya_q [NEWTON_STEPS];
	logic [32:0] y2_q [NEWTON_STEPS];
	logic [31:0] xa_q [NEWTON_STEPS];
	logic [31:0] yb_q [NEWTON_STEPS];
	logic [31:0] t_q  [NEWTON_STEPS];
	logic [31:0] xb_q [NEWTON_STEPS];
	logic [31:0] yc_q [NEWTON_STEPS];
	logic [31:0] h_q  [NEWTON_STEPS];
	logic [31:0] xc_q [NEWTON_STEPS];

	always_ff @(posedge clk) begin
		c1x_q   <= 64'(GUESS_C1) * 64'(xq);
		xg_q    <= xq;
		y_q[0]  <= GUESS_C0 - c1x_q[63:32];
		x_q[0]  <= xg_q;
	end

	for (genvar k = 0; k < NEWTON_STEPS; k++) begin : g_step
		logic [63:0] sq;
		logic [63:0] xy;
		logic [63:0] yh;

		assign sq = 64'(y_q[k]) * 64'(y_q[k]);
		assign xy = 64'(xa_q[k]) * 64'(y2_q[k]);
		assign yh = 64'(yc_q[k]) * 64'(h_q[k]);

		always_ff @(posedge clk) begin
			ya_q[k] <= y_q[k];
			y2_q[k] <= sq[62:30];
			xa_q[k] <= x_q[k];
			yb_q[k] <= ya_q[k];
			t_q[k]  <= xy[63:32];
			xb_q[k] <= xa_q[k];
			yc_q[k] <= yb_q[k];
			// clamp the correction factor at zero
			h_q[k]  <= (t_q[k] >= Q30_THREE) ? 32'd0 : Q30_THREE - t_q[k];
			xc_q[k] <= xb_q[k];
			y_q[k+1] <= (yh[62:31] > Y_CAP) ? Y_CAP : yh[62:31];
		end

		if (k < NEWTON_STEPS - 1) begin : g_x
			always_ff @(posedge clk) begin
				x_q[k+1] <= xc_q[k];
			end
		end
	end

	assign y = y_q[NEWTON_STEPS];

endmodule

`default_nettype wire

### src/nbga_pair.sv
// ----------------------------------------------------------------------------
// nbga_pair
// Pair interaction pipeline: distance, softened r^2, normalize, rsqrt,
// G*m*y^3*|d| in 32-bit partial products, shift and cap. One pair per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module nbga_pair (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  nbga_pkg::particle_t pj,
	input  logic [2:0][31:0]    pi,
	input  logic [31:0]         grav,
	input  logic [63:0]         eps2,
	output nbga_pkg::term_t     term
);
	import nbga_pkg::*;

	localparam int SD_LEN = RSQ_LAT + 10;

	typedef struct packed {
		logic             zero;
		logic [2:0]       neg;
		logic [2:0][31:0] ad;
		logic [63:0]      gm;
		logic [7:0]       sh;
	} side_t;

	logic [2:0][31:0] pjv;
	logic [2:0][32:0] d_c;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic [SD_LEN-1:0] v_q;
	logic vo_q;

	logic [2:0][31:0] ad_s1, ad_s2, ad_s3, ad_s4, ad_s5, ad_s6;
	logic [2:0]       neg_s1, neg_s2, neg_s3, neg_s4, neg_s5, neg_s6;
	logic [63:0]      gm_s1, gm_s2, gm_s3, gm_s4, gm_s5, gm_s6;
	logic [2:0][63:0] sq_s2;
	logic [64:0]      a_s3, b_s3;
	logic [65:0]      tot;
	logic [63:0]      r2_s4;
	logic [63:0]      m32, n5_s5, m8, m4, n6_s6;
	logic             z32, z16, z8, z4, z2;
	logic [5:0]       s_s5, s_s6;
	logic             zero_s5, zero_s6;
	side_t            side_in;
	side_t            side_q [SD_LEN];
	logic [31:0]      y_r;

	logic [31:0]       y_t1;
	logic [63:0]       yy_t1;
	logic [63:0]       pa_t2, pb_t2;
	logic [95:0]       yyy_t3;
	logic [1:0][2:0][63:0] pg_t4;
	logic [1:0][127:0] r_t5;
	logic [159:0]      base_t6;
	logic [2:0][4:0][63:0] pb_t7;
	logic [2:0][191:0] prod_t8, crs_t9, fin_t10;
	logic [2:0]        neg_t11, tovf_t11;
	logic              zero_t11;
	logic [2:0][62:0]  mag_t11;

	assign pjv = {pj.z, pj.y, pj.x};

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			d_c[c] = {pjv[c][31], pjv[c]} - {pi[c][31], pi[c]};
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_q  <= '0;
			vo_q <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_q  <= {v_q[SD_LEN-2:0], v_s6};
			vo_q <= v_q[SD_LEN-1];
		end
	end

	// front end: distance, r^2, normalize
	assign tot = 66'(a_s3) + 66'(b_s3);
	assign z32 = (r2_s4[63:32] == 32'd0);
	assign m32 = z32 ? {r2_s4[31:0], 32'd0} : r2_s4;
	assign z16 = (m32[63:48] == 16'd0);
	assign z8  = (n5_s5[63:56] == 8'd0);
	assign m8  = z8 ? {n5_s5[55:0], 8'd0} : n5_s5;
	assign z4  = (m8[63:60] == 4'd0);
	assign m4  = z4 ? {m8[59:0], 4'd0} : m8;
	assign z2  = (m4[63:62] == 2'd0);

	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			ad_s1[c]  <= d_c[c][32] ? 32'(33'd0 - d_c[c]) : d_c[c][31:0];
			neg_s1[c] <= d_c[c][32];
			sq_s2[c]  <= 64'(ad_s1[c]) * 64'(ad_s1[c]);
		end
		gm_s1 <= 64'(grav) * 64'(pj.m);
		ad_s2 <= ad_s1; neg_s2 <= neg_s1; gm_s2 <= gm_s1;

		a_s3 <= 65'(sq_s2[0]) + 65'(sq_s2[1]);
		b_s3 <= 65'(sq_s2[2]) + 65'(eps2);
		ad_s3 <= ad_s2; neg_s3 <= neg_s2; gm_s3 <= gm_s2;

		// saturate r^2 at all ones
		r2_s4 <= (tot[65:64] != 2'd0) ? '1 : tot[63:0];
		ad_s4 <= ad_s3; neg_s4 <= neg_s3; gm_s4 <= gm_s3;

		zero_s5 <= (r2_s4 == 64'd0);
		n5_s5   <= z16 ? {m32[47:0], 16'd0} : m32;
		s_s5    <= {z32, z16, 4'd0};
		ad_s5 <= ad_s4; neg_s5 <= neg_s4; gm_s5 <= gm_s4;

		zero_s6 <= zero_s5;
		n6_s6   <= z2 ? {m4[61:0], 2'd0} : m4;
		s_s6    <= {s_s5[5:4], z8, z4, z2, 1'b0};
		ad_s6 <= ad_s5; neg_s6 <= neg_s5; gm_s6 <= gm_s5;
	end

	always_comb begin
		side_in.zero = zero_s6;
		side_in.neg  = neg_s6;
		side_in.ad   = ad_s6;
		side_in.gm   = gm_s6;
		side_in.sh   = 8'd154 - (8'(s_s6[5:1]) * 8'd3);
	end

	nbga_rsqrt u_rsqrt (
		.clk (clk),
		.xq  (n6_s6[63:32]),
		.y   (y_r)
	);

	always_ff @(posedge clk) begin
		side_q[0] <= side_in;
		for (int k = 1; k < SD_LEN; k++) begin
			side_q[k] <= side_q[k-1];
		end
	end

	// back end: G*m*y^3*|d|, shift into Q32.32 and cap
	always_ff @(posedge clk) begin
		y_t1  <= y_r;
		yy_t1 <= 64'(y_r) * 64'(y_r);

		pa_t2 <= 64'(yy_t1[31:0]) * 64'(y_t1);
		pb_t2 <= 64'(yy_t1[63:32]) * 64'(y_t1);

		yyy_t3 <= {32'd0, pa_t2} + {pb_t2, 32'd0};

		for (int i = 0; i < 2; i++) begin
			for (int k = 0; k < 3; k++) begin
				pg_t4[i][k] <= 64'(side_q[RSQ_LAT+2].gm[32*i +: 32]) *
					64'(yyy_t3[32*k +: 32]);
			end
		end

		for (int i = 0; i < 2; i++) begin
			r_t5[i] <= {pg_t4[i][2], pg_t4[i][0]} + {32'd0, pg_t4[i][1], 32'd0};
		end

		base_t6 <= {32'd0, r_t5[0]} + {r_t5[1], 32'd0};

		for (int c = 0; c < 3; c++) begin
			for (int k = 0; k < 5; k++) begin
				pb_t7[c][k] <= 64'(base_t6[32*k +: 32]) *
					64'(side_q[RSQ_LAT+5].ad[c]);
			end
		end

		for (int c = 0; c < 3; c++) begin
			prod_t8[c] <= {pb_t7[c][4], pb_t7[c][2], pb_t7[c][0]} +
				{32'd0, pb_t7[c][3], pb_t7[c][1], 32'd0};
			crs_t9[c]  <= prod_t8[c] >> {side_q[RSQ_LAT+7].sh[7:5], 5'd0};
			fin_t10[c] <= crs_t9[c] >> side_q[RSQ_LAT+8].sh[4:0];
			tovf_t11[c] <= (fin_t10[c][191:63] != '0);
			mag_t11[c]  <= (fin_t10[c][191:63] != '0) ? '1 : fin_t10[c][62:0];
		end
		neg_t11  <= side_q[RSQ_LAT+9].neg;
		zero_t11 <= side_q[RSQ_LAT+9].zero;
	end

	assign term.valid = vo_q;
	assign term.zero  = zero_t11;
	assign term.neg   = neg_t11;
	assign term.tovf  = tovf_t11;
	assign term.mag   = mag_t11;

endmodule

`default_nettype wire

### src/nbody_gravity_acceleration.sv
// ----------------------------------------------------------------------------
// nbody_gravity_acceleration
// Direct-sum softened gravity: particle store, query sequencer, pair pipeline
// and saturating Q32.32 accumulators.
// ----------------------------------------------------------------------------
// A load (operation 0) writes the store directly and busy stays low. A query
// raises busy while it reads the queried particle, then does one store read
// per particle, each feeding the pair pipeline one interaction per cycle,
// then waits for the pipeline to drain. The result appears for exactly one
// cycle with done high and must be captured then; the outputs keep it until
// the next query is accepted. A query at an index at or beyond MAX_PARTICLES
// returns zero acceleration on the next cycle.
// Configuration registers sit at byte addresses 0, 8 and 16 (count, G, eps^2).
`default_nettype none

module nbody_gravity_acceleration #(
	parameter int MAX_PARTICLES = nbga_pkg::MAX_PARTICLES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [63:0]        pwdata,
	output logic [63:0]        prdata,
	output logic               pready,
	input  logic               start,
	output logic               busy,
	input  logic               operation,
	input  logic [9:0]         particle_index,
	input  logic signed [31:0] position_x,
	input  logic signed [31:0] position_y,
	input  logic signed [31:0] position_z,
	input  logic [31:0]        mass,
	output logic               done,
	output logic [9:0]         queried_index,
	output logic signed [63:0] accel_x,
	output logic signed [63:0] accel_y,
	output logic signed [63:0] accel_z,
	output logic               overflow
);
	import nbga_pkg::*;

	localparam int AW = $clog2(MAX_PARTICLES);
	localparam int CW = $clog2(MAX_PARTICLES + 1);
	localparam int XW = (CW > 11) ? CW : 11;

	typedef enum logic [1:0] {S_IDLE, S_FETCH, S_SWEEP, S_DRAIN} state_t;

	state_t            state_q;
	logic [10:0]       count_q;
	logic [31:0]       grav_q;
	logic [63:0]       soft_q;
	logic [9:0]        qidx_q;
	logic [XW-1:0]     j_q;
	logic              iss_q;
	logic              pi_cap_q;
	logic [2:0][31:0]  pi_q;
	logic [INFL_W-1:0] infl_q;
	logic [2:0][63:0]  acc_q;
	logic              ovf_q;
	logic              done_q;

	logic              accept;
	logic              cfg_wr;
	logic [XW-1:0]     idx_x, qidx_x, cnt_x, lim_x, cnt_eff;
	logic              in_range;
	logic              we;
	logic [AW-1:0]     raddr;
	particle_t         wdata, rdata;
	term_t             term;
	logic [2:0][64:0]  sum_c;
	logic [2:0]        sat_c;
	logic [2:0][63:0]  nxt_c;

	assign busy     = (state_q != S_IDLE);
	assign accept   = start && !busy;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign pready   = 1'b1;
	assign idx_x    = XW'(particle_index);
	assign qidx_x   = XW'(qidx_q);
	assign cnt_x    = XW'(count_q);
	assign lim_x    = XW'(MAX_PARTICLES);
	assign cnt_eff  = (cnt_x > lim_x) ? lim_x : cnt_x;
	assign in_range = (idx_x < lim_x);
	assign we       = accept && (operation == OP_LOAD) && in_range;
	assign raddr    = (state_q == S_FETCH) ? qidx_x[AW-1:0] : j_q[AW-1:0];
	assign wdata    = {mass, position_z, position_y, position_x};

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= COUNT_RST;
			grav_q  <= GRAV_RST;
			soft_q  <= SOFT_RST;
		end else if (cfg_wr) begin
			unique case (paddr[4:3])
				REG_COUNT: count_q <= pwdata[10:0];
				REG_GRAV:  grav_q  <= pwdata[31:0];
				REG_SOFT:  soft_q  <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:3])
			REG_COUNT: prdata = 64'(count_q);
			REG_GRAV:  prdata = 64'(grav_q);
			REG_SOFT:  prdata = soft_q;
			default:   prdata = 64'd0;
		endcase
	end

	nbga_ram #(
		.WIDTH ($bits(particle_t)),
		.DEPTH (MAX_PARTICLES)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (idx_x[AW-1:0]),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	nbga_pair u_pair (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (iss_q),
		.pj       (rdata),
		.pi       (pi_q),
		.grav     (grav_q),
		.eps2     (soft_q),
		.term     (term)
	);

	// saturating accumulate, sign applied to the truncated magnitude
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			sum_c[c] = term.neg[c] ?
				{acc_q[c][63], acc_q[c]} - {2'd0, term.mag[c]} :
				{acc_q[c][63], acc_q[c]} + {2'd0, term.mag[c]};
			sat_c[c] = (sum_c[c][64] != sum_c[c][63]);
			nxt_c[c] = sat_c[c] ?
				(term.neg[c] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}}) : sum_c[c][63:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			qidx_q   <= '0;
			j_q      <= '0;
			iss_q    <= 1'b0;
			pi_cap_q <= 1'b0;
			pi_q     <= '0;
			infl_q   <= '0;
			acc_q    <= '0;
			ovf_q    <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			iss_q  <= 1'b0;
			infl_q <= infl_q + INFL_W'(iss_q) - INFL_W'(term.valid);
			unique case (state_q)
				S_IDLE: begin
					if (accept && operation == OP_QUERY) begin
						qidx_q <= particle_index;
						acc_q  <= '0;
						ovf_q  <= 1'b0;
						j_q    <= '0;
						if (in_range) begin
							state_q <= S_FETCH;
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				S_FETCH: begin
					pi_cap_q <= 1'b1;
					state_q  <= S_SWEEP;
				end
				S_SWEEP: begin
					// first sweep cycle sees the queried particle on the read port
					if (pi_cap_q) begin
						pi_q     <= {rdata.z, rdata.y, rdata.x};
						pi_cap_q <= 1'b0;
					end
					if (j_q < cnt_eff) begin
						iss_q <= (j_q != qidx_x);
						j_q   <= j_q + 1'b1;
					end else begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (!iss_q && infl_q == '0) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (term.valid) begin
				if (term.zero) begin
					ovf_q <= 1'b1;
				end else begin
					acc_q <= nxt_c;
					if ((term.tovf | sat_c) != 3'd0) begin
						ovf_q <= 1'b1;
					end
				end
			end
		end
	end

	assign done          = done_q;
	assign queried_index = qidx_q;
	assign accel_x       = acc_q[0];
	assign accel_y       = acc_q[1];
	assign accel_z       = acc_q[2];
	assign overflow      = ovf_q;

endmodule

`default_nettype wire

### src/nbga_check.sv
// ----------------------------------------------------------------------------
// nbga_check
// Port-level checks on the query handshake and result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module nbga_check (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic operation,
	input logic done,
	input logic pready
);
	import nbga_pkg::*;

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready dropped");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start) && $past(operation) == OP_QUERY)
		else $error("busy without an accepted query");

	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("query ended without a result");

	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done || $past(start && operation == OP_QUERY))
		else $error("repeated result strobe");

endmodule

bind nbody_gravity_acceleration nbga_check u_check (.*);

`default_nettype wire
